// File: rtl/core/brd_pkg.sv
// ----------------------------------------------------------------------------
// brd_pkg
// Shared widths, codes and types of the block reduce decimator.
// ----------------------------------------------------------------------------
package brd_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int VALUE_W     = 40;
    localparam int RATIO_W     = 9;
    localparam int OFFSET_W    = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MAX_RATIO   = 256;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int DIV_STEPS   = VALUE_W;
    localparam int DCNT_W      = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

    typedef enum logic [1:0] {
        MODE_MIN,
        MODE_MAX,
        MODE_SUM,
        MODE_MEAN
    } t_mode;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_ADD,
        BK_DINIT,
        BK_DIV,
        BK_DFIN,
        BK_OUT
    } t_back_state;

    // One closed window handed from the front end to the back end
    typedef struct packed {
        logic [VALUE_W-1:0]  acc;
        logic [SAMPLE_W-1:0] sample;
        logic [RATIO_W-1:0]  pad;
        logic [RATIO_W-1:0]  ratio;
        t_mode               mode;
        logic                last;
    } t_job;

endpackage

// File: rtl/core/block_reduce_decimator_core.sv
// Results: a min, max or sum result passes the back-end states MUL, ADD and OUT;
// a mean result also passes DINIT, DIV (one quotient bit per cycle) and DFIN.
// Throughput: one sample per cycle while the two-entry job queue has room;
// the back end finishes one window before it takes the next from the queue.
// Reset: synchronous, active low; mode 0, ratio 1, offset 0, counters cleared.
// ----------------------------------------------------------------------------
// block_reduce_decimator_core
// Windowed min / max / sum / mean decimator for a signed Q16.16 stream.
// ----------------------------------------------------------------------------
module block_reduce_decimator_core import brd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [31:0] sample
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [VALUE_W-1:0]    m_axis_tdata,   // [39:0] value
    output logic                  m_axis_tlast
);

    t_job push_job;
    t_job head_job;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;

    brd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_sample   (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    brd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    brd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_value   (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule

// File: rtl/core/brd_front.sv
// ----------------------------------------------------------------------------
// brd_front
// Configuration registers, offset skipping and per-sample window reduction.
// Pushes one job into the queue for every window that closes.
// ----------------------------------------------------------------------------
module brd_front import brd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_last,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_job                  o_job
);

    t_mode               r_mode;
    logic [RATIO_W-1:0]  r_ratio;
    logic [OFFSET_W-1:0] r_offset;
    logic [VALUE_W-1:0]  r_acc;
    logic [RATIO_W-1:0]  r_wc;
    logic [OFFSET_W-1:0] r_skip;

    logic [RATIO_W-1:0]  eff_ratio;
    logic [VALUE_W-1:0]  s_ext;
    logic [VALUE_W-1:0]  n_acc;
    logic [RATIO_W-1:0]  n_wc;
    logic                skipping;
    logic                close;
    logic                accept;
    logic [RATIO_W-1:0]  pad;

    always_comb begin
        if (r_ratio == '0) begin
            eff_ratio = RATIO_W'(1);
        end else if (r_ratio > RATIO_W'(MAX_RATIO)) begin
            eff_ratio = RATIO_W'(MAX_RATIO);
        end else begin
            eff_ratio = r_ratio;
        end

        s_ext    = {{(VALUE_W-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};
        skipping = r_skip < r_offset;

        // first sample of a window always loads
        if (r_wc == '0) begin
            n_acc = s_ext;
        end else begin
            case (r_mode)
                MODE_MIN:  n_acc = ($signed(s_ext) < $signed(r_acc)) ? s_ext : r_acc;
                MODE_MAX:  n_acc = ($signed(s_ext) > $signed(r_acc)) ? s_ext : r_acc;
                default:   n_acc = r_acc + s_ext;
            endcase
        end

        n_wc  = r_wc + 1'b1;
        close = (n_wc >= eff_ratio) || i_last;

        // in sum and mean modes, pad a short final window with its last sample
        if ((n_wc < eff_ratio) && ((r_mode == MODE_SUM) || (r_mode == MODE_MEAN))) begin
            pad = eff_ratio - n_wc;
        end else begin
            pad = '0;
        end

        o_ready      = !i_q_full;
        accept       = i_valid && o_ready;
        o_push       = accept && !skipping && close;
        o_job.acc    = n_acc;
        o_job.sample = i_sample;
        o_job.pad    = pad;
        o_job.ratio  = eff_ratio;
        o_job.mode   = r_mode;
        o_job.last   = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_MIN;
            r_ratio  <= RATIO_W'(1);
            r_offset <= '0;
            r_acc    <= '0;
            r_wc     <= '0;
            r_skip   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MODE:   r_mode   <= t_mode'(i_cfg_data[1:0]);
                    CFG_RATIO:  r_ratio  <= i_cfg_data[RATIO_W-1:0];
                    CFG_OFFSET: r_offset <= i_cfg_data[OFFSET_W-1:0];
                    default:    ;
                endcase
            end
            if (accept) begin
                if (skipping) begin
                    if (i_last) begin
                        r_acc  <= '0;
                        r_wc   <= '0;
                        r_skip <= '0;
                    end else begin
                        r_skip <= r_skip + 1'b1;
                    end
                end else if (close) begin
                    r_acc <= '0;
                    r_wc  <= '0;
                    if (i_last) begin
                        r_skip <= '0;
                    end
                end else begin
                    r_acc <= n_acc;
                    r_wc  <= n_wc;
                end
            end
        end
    end

endmodule

// File: rtl/core/brd_queue.sv
// ----------------------------------------------------------------------------
// brd_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module brd_queue import brd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    always_comb begin
        o_empty = (r_count == '0);
        o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        o_job   = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/core/brd_back.sv
// ----------------------------------------------------------------------------
// brd_back
// Finishes one window at a time: padding product, final sum, optional
// restoring division by the ratio, and the registered result.
// ----------------------------------------------------------------------------
module brd_back import brd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_job               i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_last
);

    t_back_state         r_state;
    t_back_state         n_state;
    t_job                r_job;
    logic [VALUE_W-1:0]  r_prod;
    logic [VALUE_W-1:0]  r_sum;
    logic [VALUE_W-1:0]  r_mag;
    logic [RATIO_W-1:0]  r_rem;
    logic [DCNT_W-1:0]   r_cnt;
    logic                r_neg;
    logic [VALUE_W-1:0]  r_value;
    logic                r_last;

    logic signed [SAMPLE_W+RATIO_W:0] prod_full;
    logic [RATIO_W:0]                 rem_sh;
    logic                             rem_ge;
    logic [RATIO_W:0]                 rem_diff;
    logic [VALUE_W-1:0]               sum_now;

    always_comb begin
        prod_full = $signed(r_job.sample) * $signed({1'b0, r_job.pad});
        sum_now   = r_job.acc + r_prod;
        rem_sh    = {r_rem, r_mag[VALUE_W-1]};
        rem_ge    = rem_sh >= {1'b0, r_job.ratio};
        rem_diff  = rem_sh - {1'b0, r_job.ratio};
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_MUL;
                end
            end
            BK_MUL: n_state = BK_ADD;
            BK_ADD: begin
                n_state = (r_job.mode == MODE_MEAN) ? BK_DINIT : BK_OUT;
            end
            BK_DINIT: n_state = BK_DIV;
            BK_DIV: begin
                if (r_cnt == DCNT_W'(DIV_STEPS-1)) begin
                    n_state = BK_DFIN;
                end
            end
            BK_DFIN: n_state = BK_OUT;
            BK_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
        o_value = r_value;
        o_last  = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    r_job <= i_job;
                end
            end
            BK_MUL: r_prod <= prod_full[VALUE_W-1:0];
            BK_ADD: begin
                r_sum   <= sum_now;
                r_value <= sum_now;
                r_last  <= r_job.last;
            end
            BK_DINIT: begin
                r_neg <= r_sum[VALUE_W-1];
                r_mag <= r_sum[VALUE_W-1] ? (~r_sum + 1'b1) : r_sum;
                r_rem <= '0;
                r_cnt <= '0;
            end
            BK_DIV: begin
                // one quotient bit a cycle, shifted into the dividend register
                r_mag <= {r_mag[VALUE_W-2:0], rem_ge};
                r_rem <= rem_ge ? rem_diff[RATIO_W-1:0] : rem_sh[RATIO_W-1:0];
                r_cnt <= r_cnt + 1'b1;
            end
            BK_DFIN: begin
                r_value <= r_neg ? (~r_mag + 1'b1) : r_mag;
                r_last  <= r_job.last;
            end
            default: ;
        endcase
    end

endmodule

// File: tb/tb_block_reduce_decimator_core.sv
// ----------------------------------------------------------------------------
// tb_block_reduce_decimator_core
// Sends series of signed Q16.16 samples through the decimator while mode,
// ratio and start offset are swept, at times within a series. A bench-side
// model of the window reduction predicts every result. The output stream is
// checked in order against that prediction, on value and on the final marker.
// ----------------------------------------------------------------------------
module tb_block_reduce_decimator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import brd_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_ITEMS = 700;
    localparam int CALM_TAIL    = 120;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_sample_item;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               fin;
    } t_window_out;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [VALUE_W-1:0]    m_axis_tdata;
    logic                  m_axis_tlast;

    t_sample_item pending_samples[$];
    t_window_out  expected_windows[$];

    // bench copy of the registers and the window state
    t_mode               p_mode;
    logic [RATIO_W-1:0]  p_ratio;
    logic [OFFSET_W-1:0] p_offset;
    logic [VALUE_W-1:0]  p_acc;
    logic [RATIO_W-1:0]  p_count;
    logic [OFFSET_W-1:0] p_skip;

    logic in_took      = 1'b0;
    bit   pace_on      = 1'b0;
    int   send_gap     = 0;
    int   take_gap     = 0;
    int   errors       = 0;
    int   quiet_cycles = 0;

    block_reduce_decimator_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [31:0] sample
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [39:0] value
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Reduce one accepted sample; push the window result if it closes one
    task automatic predict_window(input logic [SAMPLE_W-1:0] smp, input logic lst);
        logic signed [VALUE_W-1:0] s40;
        logic signed [VALUE_W-1:0] acc_s;
        int unsigned               r;
        longint                    pad_prod;
        longint                    quo;
        t_window_out               res;
        s40 = {{(VALUE_W-SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
        if (p_ratio == 0)
            r = 1;
        else if (p_ratio > MAX_RATIO)
            r = MAX_RATIO;
        else
            r = p_ratio;

        if (p_skip < p_offset) begin
            p_skip = p_skip + 1'b1;
            if (lst) begin
                p_acc   = '0;
                p_count = '0;
                p_skip  = '0;
            end
            return;
        end

        acc_s = p_acc;
        if (p_count == 0) begin
            p_acc = s40;
        end else if (p_mode == MODE_MIN) begin
            if (s40 < acc_s)
                p_acc = s40;
        end else if (p_mode == MODE_MAX) begin
            if (s40 > acc_s)
                p_acc = s40;
        end else begin
            p_acc = p_acc + s40;
        end
        p_count = p_count + 1'b1;

        if (p_count < r && !lst)
            return;

        // partial final window in sum or mean: repeat the last sample up to the ratio
        if (p_count < r && (p_mode == MODE_SUM || p_mode == MODE_MEAN)) begin
            pad_prod = longint'(s40) * longint'(r - p_count);
            p_acc    = p_acc + pad_prod[VALUE_W-1:0];
        end

        res.value = p_acc;
        if (p_mode == MODE_MEAN) begin
            acc_s     = p_acc;
            quo       = longint'(acc_s) / longint'(r);
            res.value = quo[VALUE_W-1:0];
        end
        res.fin = lst;
        expected_windows.push_back(res);

        p_acc   = '0;
        p_count = '0;
        if (lst)
            p_skip = '0;
    endtask

    always @(posedge i_clk) begin : monitor
        t_window_out want;
        if (!i_rst_n) begin
            p_mode       = MODE_MIN;
            p_ratio      = 9'd1;
            p_offset     = '0;
            p_acc        = '0;
            p_count      = '0;
            p_skip       = '0;
            in_took      <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MODE:   p_mode   = t_mode'(i_cfg_data[1:0]);
                    CFG_RATIO:  p_ratio  = i_cfg_data[RATIO_W-1:0];
                    CFG_OFFSET: p_offset = i_cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            in_took <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                predict_window(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_windows.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual value %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                end else begin
                    want = expected_windows.pop_front();
                    if (m_axis_tdata !== want.value) begin
                        errors++;
                        $display("%0t: value mismatch, expected %h, actual %h",
                                 $time, want.value, m_axis_tdata);
                    end
                    if (m_axis_tlast !== want.fin) begin
                        errors++;
                        $display("%0t: last mismatch, expected %b, actual %b",
                                 $time, want.fin, m_axis_tlast);
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(negedge i_clk) begin : driver
        t_sample_item next_item;
        if (!s_axis_tvalid || in_took) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pace_on && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(0, 2);
                s_axis_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                next_item = pending_samples.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_item.sample;
                s_axis_tlast  <= next_item.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end

        if (take_gap > 0) begin
            take_gap--;
            m_axis_tready <= 1'b0;
        end else if (pace_on && $urandom_range(0, 4) == 0) begin
            take_gap = $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(negedge i_clk) begin : watchdog
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic lst);
        pending_samples.push_back('{smp, lst});
    endtask

    // Hold until every item is sent and every window result is back
    task automatic settle();
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_windows.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            4, 5:    return SAMPLE_W'($urandom_range(0, 2097151)) - SAMPLE_W'(1048576);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic logic [RATIO_W-1:0] pick_ratio();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return RATIO_W'(MAX_RATIO);
            2:       return RATIO_W'($urandom_range(MAX_RATIO + 1, 511));
            3, 4:    return RATIO_W'($urandom_range(9, 64));
            default: return RATIO_W'($urandom_range(1, 8));
        endcase
    endfunction

    initial begin : stimulus
        int    random_items;
        int    n;
        logic  lst;
        t_mode m;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: minimum over windows of one
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h0000_0000, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b1);
        settle();

        // maximum, skip two, then a full and a partial window
        write_reg(CFG_MODE, 16'(MODE_MAX));
        write_reg(CFG_RATIO, 16'd3);
        write_reg(CFG_OFFSET, 16'd2);
        push_sample(32'h1111_1111, 1'b0);
        push_sample(32'h2222_2222, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h0000_0005, 1'b0);
        push_sample(32'hFFFF_FFFD, 1'b1);
        settle();

        // sum with the partial window padded by the last sample
        write_reg(CFG_MODE, 16'(MODE_SUM));
        write_reg(CFG_RATIO, 16'd4);
        write_reg(CFG_OFFSET, 16'd0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b1);
        settle();

        // mean truncates toward zero on both signs
        write_reg(CFG_MODE, 16'(MODE_MEAN));
        write_reg(CFG_RATIO, 16'd2);
        push_sample(32'hFFFF_FFFD, 1'b0);
        push_sample(32'h0000_0000, 1'b0);
        push_sample(32'h0000_0003, 1'b0);
        push_sample(32'h0000_0000, 1'b1);
        settle();

        // widest window padded from the most negative sample
        write_reg(CFG_RATIO, 16'(MAX_RATIO));
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h8000_0000, 1'b1);
        settle();

        // end of series while still skipping, then skipping starts over
        write_reg(CFG_MODE, 16'(MODE_SUM));
        write_reg(CFG_RATIO, 16'd2);
        write_reg(CFG_OFFSET, 16'd3);
        push_sample(32'h0000_0001, 1'b0);
        push_sample(32'h0000_0002, 1'b1);
        push_sample(32'h0000_0003, 1'b0);
        push_sample(32'h0000_0004, 1'b0);
        push_sample(32'h0000_0005, 1'b0);
        push_sample(32'h0000_0006, 1'b0);
        push_sample(32'h0000_0007, 1'b1);
        settle();

        // lower the ratio and switch mode in the middle of a window
        write_reg(CFG_OFFSET, 16'd0);
        write_reg(CFG_RATIO, 16'd8);
        for (int k = 0; k < 5; k++)
            push_sample(pick_sample(), 1'b0);
        settle();
        write_reg(CFG_RATIO, 16'd3);
        write_reg(CFG_MODE, 16'(MODE_MIN));
        push_sample(pick_sample(), 1'b1);
        settle();

        // largest start offset, series ends while still skipping
        write_reg(CFG_MODE, 16'(MODE_MAX));
        write_reg(CFG_RATIO, 16'd2);
        write_reg(CFG_OFFSET, 16'hFFFF);
        for (int k = 0; k < 5; k++)
            push_sample(pick_sample(), 1'b0);
        push_sample(pick_sample(), 1'b1);
        settle();
        write_reg(CFG_OFFSET, 16'd0);

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            pace_on = (random_items < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 0) begin
                m = t_mode'($urandom_range(0, 3));
                write_reg(CFG_MODE, (CFG_DATA_W'($urandom()) & 16'hFFFC) | 16'(m));
            end
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_RATIO, (CFG_DATA_W'($urandom()) & 16'hFE00) | 16'(pick_ratio()));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_OFFSET, ($urandom_range(0, 2) == 0) ?
                          CFG_DATA_W'($urandom_range(1, 12)) : 16'd0);
            n = $urandom_range(4, 40);
            for (int k = 0; k < n; k++) begin
                // mostly whole series closed by a last item, a few cut short
                if (k == n - 1)
                    lst = ($urandom_range(0, 3) != 0);
                else
                    lst = ($urandom_range(0, 39) == 0);
                push_sample(pick_sample(), lst);
            end
            random_items += n;
            settle();
        end

        if (errors == 0 && expected_windows.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: block_reduce_decimator_core.f
rtl/core/brd_pkg.sv
rtl/core/brd_front.sv
rtl/core/brd_queue.sv
rtl/core/brd_back.sv
rtl/core/block_reduce_decimator_core.sv
tb/tb_block_reduce_decimator_core.sv
